/* hw/rtl/mbfp_pkg.sv */
`timescale 1ns / 1ps

package mbfp_pkg;

    // Positions are held wide enough for the cursor plus one field width.
    localparam int POS_W     = 13;
    localparam int CUR_W     = 12;
    localparam int FIELD_MAX = 32;

    typedef enum logic [2:0] {
        ACT_CLEAR,
        ACT_PUT,
        ACT_GET,
        ACT_APPEND,
        ACT_GET_NEXT,
        ACT_REWIND,
        ACT_LOAD_WORD,
        ACT_READ_WORD
    } action_t;

    typedef struct packed {
        action_t     action;
        logic [10:0] bit_pos;
        logic [5:0]  field_width;
        logic [31:0] field_value;
        logic [5:0]  word_index;
        logic [31:0] word_value;
    } req_t;

    typedef struct packed {
        logic [31:0]      read_value;
        logic [CUR_W-1:0] cursor_pos;
        logic             range_error;
    } rsp_t;

    // Decoded request, held between the memory read and the result register.
    typedef struct packed {
        action_t          action;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] word;
        logic [POS_W-1:0] even_row;
        logic [POS_W-1:0] odd_row;
        logic [5:0]       width;
        logic [31:0]      data;
        logic             err;
        logic             word_ok;
        logic             next_ok;
    } dec_t;

    typedef struct packed {
        logic even_wr;
        logic odd_wr;
        logic clear;
    } bank_ctl_t;

    function automatic logic [31:0] field_mask(input logic [5:0] width);
        logic [32:0] ones;
        ones = (33'd1 << width) - 33'd1;
        return ones[31:0];
    endfunction

endpackage

/* hw/rtl/mbfp_bank.sv */
`timescale 1ns / 1ps

module mbfp_bank #(
    parameter int ROWS      = 32,
    parameter int ROW_W     = 5,
    parameter int WORD_BITS = 32
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 clear,
    input  logic                 wr_en,
    input  logic [ROW_W-1:0]     wr_row,
    input  logic [WORD_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [ROW_W-1:0]     rd_row,
    output logic [WORD_BITS-1:0] rd_data
);

    logic [WORD_BITS-1:0] mem [ROWS];
    logic [ROWS-1:0]      vld_reg;
    logic [WORD_BITS-1:0] rd_word_reg;
    logic                 rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_row] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_row];
        end
    end

    // A row that has not been written since reset or the last clear reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                vld_reg <= '0;
            end
            else if (wr_en)
            begin
                vld_reg[wr_row] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_row];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_word_reg : '0;

endmodule

/* hw/rtl/mbfp_decode.sv */
`timescale 1ns / 1ps

module mbfp_decode
    import mbfp_pkg::*;
#(
    parameter int STORE_WORDS = 64,
    parameter int WORD_BITS   = 32
)(
    input  req_t             req,
    input  logic [CUR_W-1:0] cursor,
    output dec_t             dec
);

    localparam int TOTAL_BITS = STORE_WORDS * WORD_BITS;
    localparam int DIV_SH     = POS_W + 7;
    localparam int RECIP      = (2**DIV_SH + WORD_BITS - 1) / WORD_BITS;
    localparam int RECIP_W    = $clog2(RECIP + 1);
    localparam int PROD_W     = POS_W + RECIP_W;

    logic              at_cursor;
    logic              is_field;
    logic              is_word;
    logic              width_ok;
    logic              end_ok;
    logic              word_ok;
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  field_end;
    logic [POS_W-1:0]  word;
    logic [POS_W-1:0]  next_word;
    logic [PROD_W-1:0] prod;

    always_comb
    begin
        at_cursor = (req.action == ACT_APPEND) || (req.action == ACT_GET_NEXT);
        is_field  = at_cursor || (req.action == ACT_PUT) || (req.action == ACT_GET);
        is_word   = (req.action == ACT_LOAD_WORD) || (req.action == ACT_READ_WORD);
        pos       = at_cursor ? POS_W'(cursor) : POS_W'(req.bit_pos);

        // Word number by reciprocal multiplication; exact over the whole position range.
        prod      = PROD_W'(pos) * PROD_W'(RECIP);
        field_end = pos + POS_W'(req.field_width);

        width_ok  = (req.field_width != 6'd0)
                    && (32'(req.field_width) <= 32'(FIELD_MAX))
                    && (32'(req.field_width) <= 32'(WORD_BITS));
        end_ok    = 32'(field_end) <= 32'(TOTAL_BITS);

        word      = is_word ? POS_W'(req.word_index) : POS_W'(prod >> DIV_SH);
        next_word = word + POS_W'(1);
        word_ok   = is_word ? (32'(req.word_index) < 32'(STORE_WORDS)) : (width_ok && end_ok);

        dec.action   = req.action;
        dec.pos      = pos;
        dec.word     = word;
        dec.even_row = (word + POS_W'(word[0])) >> 1;
        dec.odd_row  = word >> 1;
        dec.width    = req.field_width;
        dec.data     = is_word ? req.word_value
                               : (req.field_value & field_mask(req.field_width));
        dec.err      = (is_field || is_word) && !word_ok;
        dec.word_ok  = (is_field || is_word) && word_ok;
        dec.next_ok  = is_field && word_ok && (32'(next_word) < 32'(STORE_WORDS));
    end

endmodule

/* hw/rtl/mbfp_field.sv */
`timescale 1ns / 1ps

module mbfp_field
    import mbfp_pkg::*;
#(
    parameter int WORD_BITS = 32
)(
    input  logic                 stage_vld,
    input  dec_t                 dec,
    input  logic [CUR_W-1:0]     cursor,
    input  logic [WORD_BITS-1:0] even_data,
    input  logic [WORD_BITS-1:0] odd_data,
    output bank_ctl_t            ctl,
    output logic [WORD_BITS-1:0] even_wr_data,
    output logic [WORD_BITS-1:0] odd_wr_data,
    output rsp_t                 rsp_next
);

    localparam int DW    = 2 * WORD_BITS;
    localparam int OFS_W = $clog2(WORD_BITS);
    localparam int SH_W  = $clog2(DW + 1);

    logic [WORD_BITS-1:0]    first_word;
    logic [WORD_BITS-1:0]    second_word;
    logic [WORD_BITS-1:0]    first_new;
    logic [WORD_BITS-1:0]    second_new;
    logic [WORD_BITS-1:0]    load_word;
    logic [DW-1:0]           dbl;
    logic [DW-1:0]           merged;
    logic [DW+31:0]          ins_wide;
    logic [DW+31:0]          get_wide;
    logic [WORD_BITS+31:0]   data_wide;
    logic [WORD_BITS+31:0]   word_wide;
    logic [POS_W-1:0]        in_word;
    logic [POS_W-1:0]        field_end;
    logic [OFS_W-1:0]        ofs;
    logic [SH_W-1:0]         sh;
    logic [31:0]             got;
    logic                    wr_first;
    logic                    wr_second;
    logic                    clear_req;

    // The field sits in the double word {first, second}, MSB first.
    always_comb
    begin
        first_word  = dec.word_ok ? (dec.word[0] ? odd_data : even_data) : '0;
        second_word = dec.next_ok ? (dec.word[0] ? even_data : odd_data) : '0;
        dbl         = {first_word, second_word};

        in_word   = dec.pos - (dec.word * POS_W'(WORD_BITS));
        ofs       = in_word[OFS_W-1:0];
        sh        = SH_W'(DW) - SH_W'(ofs) - SH_W'(dec.width);
        field_end = dec.pos + POS_W'(dec.width);

        ins_wide  = (DW + 32)'(dec.data) << sh;
        merged    = dbl | ins_wide[DW-1:0];
        get_wide  = (DW + 32)'(dbl) >> sh;
        got       = get_wide[31:0] & field_mask(dec.width);

        data_wide = (WORD_BITS + 32)'(dec.data);
        load_word = data_wide[WORD_BITS-1:0];
        word_wide = (WORD_BITS + 32)'(first_word);

        first_new  = (dec.action == ACT_LOAD_WORD) ? load_word : merged[DW-1:WORD_BITS];
        second_new = merged[WORD_BITS-1:0];
    end

    always_comb
    begin
        wr_first             = 1'b0;
        wr_second            = 1'b0;
        clear_req            = 1'b0;
        rsp_next.read_value  = '0;
        rsp_next.cursor_pos  = cursor;
        rsp_next.range_error = dec.err;
        case (dec.action)
            ACT_CLEAR:
            begin
                clear_req           = 1'b1;
                rsp_next.cursor_pos = '0;
            end
            ACT_PUT, ACT_APPEND:
            begin
                if (!dec.err)
                begin
                    wr_first  = 1'b1;
                    wr_second = dec.next_ok;
                    if (dec.action == ACT_APPEND)
                    begin
                        rsp_next.cursor_pos = field_end[CUR_W-1:0];
                    end
                end
            end
            ACT_GET, ACT_GET_NEXT:
            begin
                if (!dec.err)
                begin
                    rsp_next.read_value = got;
                    if (dec.action == ACT_GET_NEXT)
                    begin
                        rsp_next.cursor_pos = field_end[CUR_W-1:0];
                    end
                end
            end
            ACT_REWIND:
            begin
                rsp_next.cursor_pos = '0;
            end
            ACT_LOAD_WORD:
            begin
                wr_first = !dec.err;
            end
            ACT_READ_WORD:
            begin
                if (!dec.err)
                begin
                    rsp_next.read_value = word_wide[31:0];
                end
            end
            default:
            begin
                rsp_next.read_value = '0;
            end
        endcase
    end

    always_comb
    begin
        ctl.clear    = stage_vld && clear_req;
        ctl.even_wr  = stage_vld && (dec.word[0] ? wr_second : wr_first);
        ctl.odd_wr   = stage_vld && (dec.word[0] ? wr_first : wr_second);
        even_wr_data = dec.word[0] ? second_new : first_new;
        odd_wr_data  = dec.word[0] ? first_new : second_new;
    end

endmodule

/* hw/rtl/msb_first_bit_field_packer.sv */
`timescale 1ns / 1ps

// MSB-first bit-field packer. The store is STORE_WORDS words of WORD_BITS bits,
// seen as one bit string whose bit 0 is the MSB of word 0.
// A request is taken on a rising edge with start high and busy low. The request
// struct carries the action, the field position, width and value, and the word
// index and value for whole-word loads and reads.
// The memory is split into an even-word bank and an odd-word bank, so a field
// that straddles two words reads both together and writes both back together.
// The bank read is issued at the accepting edge; the next cycle merges or
// extracts the field and loads the result register. busy is high for that one
// cycle, so no new request is taken while one is in the work stage.
// done is registered from the work-stage valid and rises as the result register
// is loaded; it is high for exactly one cycle with the result on rsp. The
// receiver cannot stall; each result is shown once.
// Reset clears the cursor and the per-row valid bits, so every word reads as
// zero with no clearing pass; the clear action does the same.
module msb_first_bit_field_packer
    import mbfp_pkg::*;
#(
    parameter int STORE_WORDS = 64,
    parameter int WORD_BITS   = 32
)(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t req,
    output logic busy,
    output logic done,
    output rsp_t rsp
);

    localparam int EVEN_ROWS = (STORE_WORDS + 1) / 2;
    localparam int ODD_ROWS  = STORE_WORDS / 2;
    localparam int EROW_W    = (EVEN_ROWS > 1) ? $clog2(EVEN_ROWS) : 1;
    localparam int OROW_W    = (ODD_ROWS > 1) ? $clog2(ODD_ROWS) : 1;

    logic                 accept;
    dec_t                 dec;
    dec_t                 dec_reg;
    logic                 stage_vld_reg;
    logic                 done_reg;
    logic [CUR_W-1:0]     cursor_reg;
    rsp_t                 rsp_next;
    rsp_t                 rsp_reg;
    bank_ctl_t            ctl;
    logic [WORD_BITS-1:0] even_rd_data;
    logic [WORD_BITS-1:0] odd_rd_data;
    logic [WORD_BITS-1:0] even_wr_data;
    logic [WORD_BITS-1:0] odd_wr_data;
    logic                 even_rd_en;
    logic                 odd_rd_en;

    assign accept = start && !stage_vld_reg;

    mbfp_decode #(
        .STORE_WORDS (STORE_WORDS),
        .WORD_BITS   (WORD_BITS)
    ) u_decode (
        .req    (req),
        .cursor (cursor_reg),
        .dec    (dec)
    );

    assign even_rd_en = accept && (dec.word[0] ? dec.next_ok : dec.word_ok);
    assign odd_rd_en  = accept && (dec.word[0] ? dec.word_ok : dec.next_ok);

    mbfp_bank #(
        .ROWS      (EVEN_ROWS),
        .ROW_W     (EROW_W),
        .WORD_BITS (WORD_BITS)
    ) u_even_bank (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (ctl.clear),
        .wr_en   (ctl.even_wr),
        .wr_row  (dec_reg.even_row[EROW_W-1:0]),
        .wr_data (even_wr_data),
        .rd_en   (even_rd_en),
        .rd_row  (dec.even_row[EROW_W-1:0]),
        .rd_data (even_rd_data)
    );

    mbfp_bank #(
        .ROWS      (ODD_ROWS),
        .ROW_W     (OROW_W),
        .WORD_BITS (WORD_BITS)
    ) u_odd_bank (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (ctl.clear),
        .wr_en   (ctl.odd_wr),
        .wr_row  (dec_reg.odd_row[OROW_W-1:0]),
        .wr_data (odd_wr_data),
        .rd_en   (odd_rd_en),
        .rd_row  (dec.odd_row[OROW_W-1:0]),
        .rd_data (odd_rd_data)
    );

    mbfp_field #(
        .WORD_BITS (WORD_BITS)
    ) u_field (
        .stage_vld    (stage_vld_reg),
        .dec          (dec_reg),
        .cursor       (cursor_reg),
        .even_data    (even_rd_data),
        .odd_data     (odd_rd_data),
        .ctl          (ctl),
        .even_wr_data (even_wr_data),
        .odd_wr_data  (odd_wr_data),
        .rsp_next     (rsp_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_vld_reg <= 1'b0;
            done_reg      <= 1'b0;
            cursor_reg    <= '0;
        end
        else
        begin
            stage_vld_reg <= accept;
            done_reg      <= stage_vld_reg;
            if (stage_vld_reg)
            begin
                cursor_reg <= rsp_next.cursor_pos;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dec_reg <= dec;
        end
        if (stage_vld_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign busy = stage_vld_reg;
    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_done_follows_stage: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(stage_vld_reg))
        else $error("result strobe without a request in the work stage");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        stage_vld_reg |=> !stage_vld_reg)
        else $error("work stage held a request for two cycles");

    a_error_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && rsp_reg.range_error) |-> (rsp_reg.read_value == '0))
        else $error("refused request returned data");

    a_error_keeps_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && rsp_reg.range_error) |-> $stable(cursor_reg))
        else $error("refused request moved the cursor");

    a_writes_in_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.even_wr || ctl.odd_wr || ctl.clear) |-> stage_vld_reg)
        else $error("store written with no request in the work stage");

endmodule

/* tb/sv/bitstring_checker.sv */
`timescale 1ns / 1ps

module bitstring_checker
    import mbfp_pkg::*;
#(
    parameter int WORDS = 64,
    parameter int BITS  = 32
)(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic busy,
    input  req_t req,
    input  logic done,
    input  rsp_t rsp,
    output int   fail_count,
    output int   pending,
    output int   rsp_checked
);

    logic [BITS-1:0]  mirror_words [WORDS];
    logic [CUR_W-1:0] mirror_cursor;
    rsp_t             due_rsp [$];

    // Applies one request to the mirrored store and cursor and returns the
    // response the block must give for it.
    function automatic rsp_t apply_request(input req_t r);
        rsp_t o;
        int   pos;
        int   w;
        int   p;
        int   i;
        logic from_cursor;
        logic is_write;
        o = '0;
        w = int'(r.field_width);
        case (r.action)
            ACT_CLEAR:
            begin
                for (i = 0; i < WORDS; i++)
                    mirror_words[i] = '0;
                mirror_cursor = '0;
            end
            ACT_PUT, ACT_GET, ACT_APPEND, ACT_GET_NEXT:
            begin
                from_cursor = (r.action == ACT_APPEND) || (r.action == ACT_GET_NEXT);
                is_write    = (r.action == ACT_PUT) || (r.action == ACT_APPEND);
                pos = from_cursor ? int'(mirror_cursor) : int'(r.bit_pos);
                if (w == 0 || w > FIELD_MAX || w > BITS || pos + w > WORDS * BITS)
                    o.range_error = 1'b1;
                else
                begin
                    // Bit 0 of the string is the MSB of word 0; only the low
                    // w bits of the value take part.
                    for (i = 0; i < w; i++)
                    begin
                        p = pos + i;
                        if (is_write)
                            mirror_words[p / BITS][BITS - 1 - p % BITS] =
                                mirror_words[p / BITS][BITS - 1 - p % BITS] |
                                r.field_value[w - 1 - i];
                        else
                            o.read_value = {o.read_value[30:0],
                                            mirror_words[p / BITS][BITS - 1 - p % BITS]};
                    end
                    if (from_cursor)
                        mirror_cursor = CUR_W'(pos + w);
                end
            end
            ACT_REWIND:
                mirror_cursor = '0;
            ACT_LOAD_WORD:
            begin
                if (int'(r.word_index) >= WORDS)
                    o.range_error = 1'b1;
                else
                    mirror_words[r.word_index] = BITS'(r.word_value);
            end
            default:
            begin
                if (int'(r.word_index) >= WORDS)
                    o.range_error = 1'b1;
                else
                    o.read_value = 32'(mirror_words[r.word_index]);
            end
        endcase
        o.cursor_pos = mirror_cursor;
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        rsp_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < WORDS; i++)
                mirror_words[i] = '0;
            mirror_cursor = '0;
            due_rsp.delete();
            pending <= 0;
        end
        else
        begin
            if (done)
            begin
                if (due_rsp.size() == 0)
                begin
                    $display("%0t: response with no request outstanding: %h", $time, rsp);
                    fail_count++;
                end
                else
                begin
                    want = due_rsp.pop_front();
                    rsp_checked++;
                    if (rsp.read_value !== want.read_value)
                    begin
                        $display("%0t: read_value expected %h got %h",
                                 $time, want.read_value, rsp.read_value);
                        fail_count++;
                    end
                    if (rsp.cursor_pos !== want.cursor_pos)
                    begin
                        $display("%0t: cursor_pos expected %0d got %0d",
                                 $time, want.cursor_pos, rsp.cursor_pos);
                        fail_count++;
                    end
                    if (rsp.range_error !== want.range_error)
                    begin
                        $display("%0t: range_error expected %b got %b",
                                 $time, want.range_error, rsp.range_error);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                due_rsp.insert(due_rsp.size(), apply_request(req));
            pending <= due_rsp.size();
        end
    end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
    import mbfp_pkg::*;

    localparam int STORE_WORDS = 64;
    localparam int WORD_BITS   = 32;
    localparam int STRING_BITS = STORE_WORDS * WORD_BITS;
    localparam int ITEM_TARGET = 1925;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t req   = '0;
    logic busy;
    logic done;
    rsp_t rsp;

    int fail_count;
    int pending;
    int rsp_checked;

    int   sent = 0;
    int   act_count [8];
    logic no_idle = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    msb_first_bit_field_packer #(
        .STORE_WORDS(STORE_WORDS),
        .WORD_BITS  (WORD_BITS)
    ) DUT (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .req  (req),
        .busy (busy),
        .done (done),
        .rsp  (rsp)
    );

    bitstring_checker #(
        .WORDS(STORE_WORDS),
        .BITS (WORD_BITS)
    ) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .done       (done),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending),
        .rsp_checked(rsp_checked)
    );

    // Sends one request after a random pause. start stays high between
    // back-to-back requests so it is never dropped and raised in one step.
    task automatic issue(input action_t a, input int pos, input int w,
                         input logic [31:0] fv, input int idx, input logic [31:0] wv);
        int   gap;
        req_t r;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        r.action      = a;
        r.bit_pos     = pos[10:0];
        r.field_width = w[5:0];
        r.field_value = fv;
        r.word_index  = idx[5:0];
        r.word_value  = wv;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req   <= r;
        do
            @(posedge clk);
        while (busy);
        act_count[int'(a)]++;
        sent++;
    endtask

    // Writes a run of fields at the cursor, then rewinds and reads them back.
    // A full run packs the whole store to its last bit and then runs off the end.
    task automatic stream_run();
        int widths [$];
        int fill_up;
        int n;
        int cur;
        int w;
        fill_up = ($urandom_range(0, 5) == 0);
        n       = $urandom_range(1, 40);
        cur     = 0;
        if ($urandom_range(0, 1) == 0)
            issue(ACT_CLEAR, $urandom_range(0, 2047), $urandom_range(0, 63), $urandom(),
                  $urandom_range(0, 63), $urandom());
        else
            issue(ACT_REWIND, $urandom_range(0, 2047), $urandom_range(0, 63), $urandom(),
                  $urandom_range(0, 63), $urandom());
        while (fill_up ? (cur < STRING_BITS) : (widths.size() < n))
        begin
            w = $urandom_range(1, 32);
            if (cur + w > STRING_BITS)
                w = STRING_BITS - cur;
            issue(ACT_APPEND, $urandom_range(0, 2047), w, $urandom(),
                  $urandom_range(0, 63), $urandom());
            widths.insert(widths.size(), w);
            cur += w;
            if ($urandom_range(0, 9) == 0)
                issue($urandom_range(0, 1) ? ACT_PUT : ACT_GET, $urandom_range(0, 2047),
                      $urandom_range(1, 32), $urandom(), $urandom_range(0, 63), $urandom());
        end
        if (fill_up)
        begin
            issue(ACT_APPEND, 0, $urandom_range(1, 32), $urandom(), 0, $urandom());
            issue(ACT_GET_NEXT, 0, $urandom_range(1, 32), $urandom(), 0, $urandom());
        end
        issue(ACT_REWIND, $urandom_range(0, 2047), $urandom_range(0, 63), $urandom(),
              $urandom_range(0, 63), $urandom());
        foreach (widths[k])
            issue(ACT_GET_NEXT, $urandom_range(0, 2047), widths[k], $urandom(),
                  $urandom_range(0, 63), $urandom());
    endtask

    task automatic word_run();
        int idx;
        int k;
        for (k = $urandom_range(1, 4); k > 0; k--)
        begin
            idx = $urandom_range(0, 63);
            issue(ACT_LOAD_WORD, $urandom_range(0, 2047), $urandom_range(0, 63), $urandom(),
                  idx, $urandom());
            issue(ACT_GET, idx * WORD_BITS + $urandom_range(0, 31), $urandom_range(1, 32),
                  $urandom(), $urandom_range(0, 63), $urandom());
            issue(ACT_READ_WORD, $urandom_range(0, 2047), $urandom_range(0, 63), $urandom(),
                  idx, $urandom());
        end
    endtask

    task automatic loose_run();
        action_t a;
        int      pos;
        int      w;
        int      k;
        for (k = $urandom_range(5, 20); k > 0; k--)
        begin
            a = action_t'($urandom_range(0, 7));
            // Clearing too often would keep the store nearly empty.
            if (a == ACT_CLEAR && $urandom_range(0, 3) != 0)
                a = ACT_PUT;
            pos = ($urandom_range(0, 3) == 0) ? $urandom_range(1990, 2047)
                                              : $urandom_range(0, 2047);
            w   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 32);
            issue(a, pos, w, $urandom(), $urandom_range(0, 63), $urandom());
        end
    endtask

    initial
    begin
        #3_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        foreach (act_count[k])
            act_count[k] = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: store ends, straddling fields, bad widths, masking,
        // OR-only inserts and the cursor actions.
        issue(ACT_READ_WORD, 0, 0, 32'h0, 0, 32'h0);
        issue(ACT_LOAD_WORD, 0, 0, 32'h0, 63, 32'h8000_0001);
        issue(ACT_LOAD_WORD, 0, 0, 32'h0, 0, 32'hFFFF_FFFF);
        issue(ACT_READ_WORD, 0, 0, 32'h0, 63, 32'h0);
        issue(ACT_PUT, 2047, 1, 32'hFFFF_FFFF, 0, 32'h0);
        issue(ACT_GET, 2016, 32, 32'h0, 0, 32'h0);
        issue(ACT_GET, 0, 32, 32'h0, 0, 32'h0);
        issue(ACT_PUT, 2047, 2, 32'hFFFF_FFFF, 0, 32'h0);
        issue(ACT_GET, 2017, 32, 32'h0, 0, 32'h0);
        issue(ACT_PUT, 100, 0, 32'hFFFF_FFFF, 0, 32'h0);
        issue(ACT_GET, 100, 33, 32'h0, 0, 32'h0);
        issue(ACT_PUT, 100, 63, 32'hFFFF_FFFF, 0, 32'h0);
        issue(ACT_CLEAR, 2047, 63, 32'hFFFF_FFFF, 63, 32'hFFFF_FFFF);
        issue(ACT_PUT, 20, 32, 32'hF0F0_1234, 0, 32'h0);
        issue(ACT_GET, 20, 32, 32'h0, 0, 32'h0);
        issue(ACT_PUT, 40, 3, 32'hFFFF_FFF8, 0, 32'h0);
        issue(ACT_PUT, 16, 8, 32'h0000_00FF, 0, 32'h0);
        issue(ACT_READ_WORD, 0, 0, 32'h0, 0, 32'h0);
        issue(ACT_READ_WORD, 0, 0, 32'h0, 1, 32'h0);
        issue(ACT_APPEND, 0, 32, 32'hDEAD_BEEF, 0, 32'h0);
        issue(ACT_APPEND, 0, 1, 32'h0000_0001, 0, 32'h0);
        issue(ACT_GET_NEXT, 0, 31, 32'h0, 0, 32'h0);
        issue(ACT_REWIND, 0, 0, 32'h0, 0, 32'h0);
        issue(ACT_GET_NEXT, 0, 32, 32'h0, 0, 32'h0);
        issue(ACT_GET_NEXT, 0, 0, 32'h0, 0, 32'h0);

        while (sent < ITEM_TARGET)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: stream_run();
                4, 5:       word_run();
                default:    loose_run();
            endcase
        end

        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);

        $display("Sent %0d requests: clear %0d, put %0d, get %0d, append %0d, get-next %0d,",
                 sent, act_count[0], act_count[1], act_count[2], act_count[3], act_count[4]);
        $display("rewind %0d, load word %0d, read word %0d; %0d responses compared.",
                 act_count[5], act_count[6], act_count[7], rsp_checked);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
